// ===== rtl/fcfs_multi_server_job_scheduler_assert.svh =====
// Assertion macros for the FCFS multi-server job scheduler checker.
// Used by the checker file; depends on nothing else.
`ifndef FCFS_MULTI_SERVER_JOB_SCHEDULER_ASSERT_SVH
`define FCFS_MULTI_SERVER_JOB_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcfs scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define FCFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcfs scheduler assertion failed");

`endif

// ===== rtl/fcfs_pkg.sv =====
// Shared types and constants of the FCFS multi-server job scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcfs_pkg;

  // Field widths fixed by the item formats.
  localparam int ID_W       = 7;
  localparam int OPND_W     = 7;
  localparam int TIME_W     = 14;
  localparam int SRV_W      = 3;
  localparam int NS_W       = 4;
  localparam int RESULT_CAP = 8;
  localparam int QUEUE_DEPTH = 2;

  // Stream data widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Bit positions inside out_tdata.
  localparam int OB_SRV_LSB  = 0;
  localparam int OB_BUSY     = 3;
  localparam int OB_ID_LSB   = 4;
  localparam int OB_LEFT_LSB = 11;
  localparam int OB_DROP     = 25;
  localparam int OB_DONE     = 26;
  localparam int OB_USED     = 27;

  // Operation and result kind codes.
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_SLOT  = 1'b1;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] svc_time;
  } cmd_t;

  // One job table entry.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] left;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [SRV_W-1:0]  server;
    logic              slot_busy;
    logic [ID_W-1:0]   served_id;
    logic [TIME_W-1:0] time_left;
    logic              dropped;
    logic              all_done;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/fcfs_front.sv =====
// Front part: accepts input items, unpacks and classifies them and computes
// the service time of an arrival. Depends on fcfs_pkg.
`default_nettype none

module fcfs_front
  import fcfs_pkg::*;
(
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output cmd_t                       push_cmd
);

  logic [OPND_W-1:0]   weight;
  logic [OPND_W-1:0]   amount;
  logic [2*OPND_W-1:0] prod;

  // Unpack the arrival fields.
  assign weight = in_tdata[ID_W +: OPND_W];
  assign amount = in_tdata[ID_W+OPND_W +: OPND_W];

  // Service time is weight times amount; it always fits the time field.
  assign prod = weight * amount;

  // An item is taken whenever the queue has room.
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_cmd.op       = in_tuser;
    push_cmd.job_id   = in_tdata[ID_W-1:0];
    push_cmd.svc_time = prod[TIME_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/fcfs_queue.sv =====
// Short command queue between the front and the back of the scheduler.
// Depends on fcfs_pkg for the command type and depth.
`default_nettype none

module fcfs_queue
  import fcfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcfs_back.sv =====
// Back part: owns the job table, carries out arrivals and ticks and drives
// the result register. Depends on fcfs_pkg.
`default_nettype none

module fcfs_back
  import fcfs_pkg::*;
#(
  parameter int MAX_JOBS    = 64,
  parameter int MAX_SERVERS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire cmd_t            cmd,
  input  wire logic [NS_W-1:0] num_servers,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output res_t                 res
);

  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int SLOT_CAP = (MAX_SERVERS < RESULT_CAP) ? MAX_SERVERS : RESULT_CAP;
  localparam int SLOT_W   = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] job_cnt_r, job_cnt_nxt;
  logic [CNT_W-1:0] busy_cnt_r, busy_cnt_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [NS_W-1:0]  served_r, served_nxt;
  logic [NS_W-1:0]  emit_r, emit_nxt;
  logic             out_vld_r, out_vld_nxt;
  res_t             out_res_r, out_res_nxt;

  entry_t           table_mem [MAX_JOBS];
  entry_t           rd_data_r;
  entry_t           slot_buf_r [SLOT_CAP];
  entry_t           slot_sel;

  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;
  entry_t           mem_wdata;
  logic             mem_re;
  logic             buf_we;
  logic             issue;
  logic             out_free;
  logic [NS_W-1:0]  lim;

  // Servers per tick: zero acts as one, large values saturate.
  always_comb begin
    lim = num_servers;
    if (lim == '0) begin
      lim = NS_W'(1);
    end
    if (lim > NS_W'(SLOT_CAP)) begin
      lim = NS_W'(SLOT_CAP);
    end
  end

  assign out_free  = !out_vld_r || res_ready;
  assign res_valid = out_vld_r;
  assign res       = out_res_r;

  // Sequencer for arrivals, table scan and slot emission.
  always_comb begin
    state_nxt    = state_r;
    job_cnt_nxt  = job_cnt_r;
    busy_cnt_nxt = busy_cnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_vld_nxt   = rd_vld_r;
    rd_idx_nxt   = rd_idx_r;
    served_nxt   = served_r;
    emit_nxt     = emit_r;
    out_vld_nxt  = out_vld_r && !res_ready;
    out_res_nxt  = out_res_r;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_widx     = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    buf_we       = 1'b0;
    issue        = 1'b0;
    slot_sel     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_TICK) begin
            cmd_ready  = 1'b1;
            rd_ptr_nxt = '0;
            rd_vld_nxt = 1'b0;
            served_nxt = '0;
            state_nxt  = S_SCAN;
          end else if (out_free) begin
            // Arrival: append the job unless the table is full.
            cmd_ready             = 1'b1;
            out_res_nxt           = '0;
            out_res_nxt.kind      = KIND_ACK;
            out_res_nxt.served_id = cmd.job_id;
            out_res_nxt.last      = 1'b1;
            if (job_cnt_r == CNT_W'(MAX_JOBS)) begin
              out_res_nxt.dropped = 1'b1;
            end else begin
              mem_we                = 1'b1;
              mem_widx              = job_cnt_r[IDX_W-1:0];
              mem_wdata.id          = cmd.job_id;
              mem_wdata.left        = cmd.svc_time;
              job_cnt_nxt           = job_cnt_r + 1'b1;
              out_res_nxt.time_left = cmd.svc_time;
              if (cmd.svc_time != '0) begin
                busy_cnt_nxt = busy_cnt_r + 1'b1;
              end
            end
            out_res_nxt.all_done = (busy_cnt_nxt == '0);
            out_vld_nxt          = 1'b1;
          end
        end
      end

      S_SCAN: begin
        // Entry read last cycle: serve it if unfinished and a server is free.
        if (rd_vld_r && (rd_data_r.left != '0) && (served_r < lim)) begin
          buf_we         = 1'b1;
          served_nxt     = served_r + 1'b1;
          mem_we         = 1'b1;
          mem_widx       = rd_idx_r;
          mem_wdata.id   = rd_data_r.id;
          mem_wdata.left = rd_data_r.left - 1'b1;
          if (rd_data_r.left == TIME_W'(1)) begin
            busy_cnt_nxt = busy_cnt_r - 1'b1;
          end
        end
        // Read the next entry while servers remain.
        issue = (rd_ptr_r < job_cnt_r) && (served_nxt < lim);
        if (issue) begin
          mem_re     = 1'b1;
          rd_idx_nxt = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        rd_vld_nxt = issue;
        if (!rd_vld_r && !issue) begin
          emit_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_res_nxt        = '0;
          out_res_nxt.kind   = KIND_SLOT;
          out_res_nxt.server = emit_r[SRV_W-1:0];
          if (emit_r < served_r) begin
            slot_sel                = slot_buf_r[emit_r[SLOT_W-1:0]];
            out_res_nxt.slot_busy   = 1'b1;
            out_res_nxt.served_id   = slot_sel.id;
            out_res_nxt.time_left   = slot_sel.left;
          end
          out_res_nxt.all_done = (busy_cnt_r == '0);
          out_res_nxt.last     = (emit_r == lim - 1'b1);
          out_vld_nxt          = 1'b1;
          emit_nxt             = emit_r + 1'b1;
          if (emit_r == lim - 1'b1) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Job table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_widx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[rd_ptr_r[IDX_W-1:0]];
    end
  end

  // Entries served during this tick, in server order.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      slot_buf_r[served_r[SLOT_W-1:0]] <= rd_data_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      job_cnt_r  <= '0;
      busy_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      job_cnt_r  <= job_cnt_nxt;
      busy_cnt_r <= busy_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Scan pointers, counters and the result payload.
  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    served_r  <= served_nxt;
    emit_r    <= emit_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/fcfs_multi_server_job_scheduler.sv =====
// FCFS multi-server job scheduler, top level: configuration register,
// stream packing and the front, queue and back parts. Depends on fcfs_pkg.
//
// Jobs arrive on the input stream (tuser 0) and are appended to a table of
// MAX_JOBS entries; a tick (tuser 1) gives one unit of service to each of the
// first num_servers unfinished jobs in arrival order and reports one slot per
// server. An arrival is answered with one acknowledgement in the cycle after it
// leaves the command queue. A tick reads the job table through its single
// read port, one entry per cycle, from the start of the table until the
// servers are filled or the stored jobs are exhausted, and then outputs one
// slot per server, with servers counted as num_servers saturated to
// min(MAX_SERVERS, 8). The two-entry queue behind the input lets new items
// be taken while a tick is being worked. The table needs no clearing after
// reset: only entries below the job count are ever read. num_servers is
// written through cfg_we and resets to 1; the user must write it only while
// the block is idle, which the block itself does not enforce.
`default_nettype none

module fcfs_multi_server_job_scheduler
  import fcfs_pkg::*;
#(
  parameter int MAX_JOBS    = 64,
  parameter int MAX_SERVERS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: num_servers.
  input  wire logic                   cfg_we,
  input  wire logic [NS_W-1:0]        cfg_wdata,
  // Input items.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_tdata: job_id[6:0], weight[13:7], amount[20:14], zero [23:21].
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op.
  input  wire logic                   in_tuser,
  // Result items.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_tdata: server[2:0], slot_busy[3], served_id[10:4],
  // time_left[24:11], dropped[25], all_done[26], zero [31:27].
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: kind.
  output logic                        out_tuser,
  output logic                        out_tlast
);

  logic [NS_W-1:0] ns_r;
  logic            push_valid;
  logic            push_ready;
  cmd_t            push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  cmd_t            pop_cmd;
  res_t            res;

  // Server count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= NS_W'(1);
    end else if (cfg_we) begin
      ns_r <= cfg_wdata;
    end
  end

  fcfs_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fcfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fcfs_back #(
    .MAX_JOBS    (MAX_JOBS),
    .MAX_SERVERS (MAX_SERVERS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_cmd),
    .num_servers (ns_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  // Pack the result item onto the output stream.
  always_comb begin
    out_tdata                             = '0;
    out_tdata[OB_SRV_LSB +: SRV_W]        = res.server;
    out_tdata[OB_BUSY]                    = res.slot_busy;
    out_tdata[OB_ID_LSB +: ID_W]          = res.served_id;
    out_tdata[OB_LEFT_LSB +: TIME_W]      = res.time_left;
    out_tdata[OB_DROP]                    = res.dropped;
    out_tdata[OB_DONE]                    = res.all_done;
  end

  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/fcfs_checker.sv =====
// Port-level checker for the FCFS multi-server job scheduler and its bind.
// Depends on fcfs_pkg and fcfs_multi_server_job_scheduler_assert.svh.
`default_nettype none

`include "fcfs_multi_server_job_scheduler_assert.svh"

module fcfs_checker
  import fcfs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   out_tlast
);

  // An acknowledgement is always the only result of its arrival.
  `FCFS_ASSERT_IMPLY(a_ack_last, clk, rst_n, out_tvalid && (out_tuser == KIND_ACK), out_tlast)

  // A dropped arrival is an acknowledgement with no service time.
  `FCFS_ASSERT_IMPLY(a_drop_ack, clk, rst_n, out_tvalid && out_tdata[OB_DROP], (out_tuser == KIND_ACK) && (out_tdata[OB_LEFT_LSB +: TIME_W] == '0))

  // An idle slot carries no job id and no time.
  `FCFS_ASSERT_IMPLY(a_idle_slot, clk, rst_n, out_tvalid && (out_tuser == KIND_SLOT) && !out_tdata[OB_BUSY], (out_tdata[OB_ID_LSB +: ID_W] == '0) && (out_tdata[OB_LEFT_LSB +: TIME_W] == '0))

  // Slots of one tick follow each other in server order.
  `FCFS_ASSERT_NEXT(a_slot_order, clk, rst_n, out_tvalid && out_tready && (out_tuser == KIND_SLOT) && !out_tlast, !out_tvalid || ((out_tuser == KIND_SLOT) && (out_tdata[OB_SRV_LSB +: SRV_W] == SRV_W'($past(out_tdata[OB_SRV_LSB +: SRV_W]) + 1'b1))))

  // A stalled result holds.
  `FCFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind fcfs_multi_server_job_scheduler fcfs_checker u_fcfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the FCFS multi-server job scheduler.
// Depends on fcfs_pkg and fcfs_multi_server_job_scheduler; reads no files.
// A scoreboard class predicts every result item, and plain tasks drive the streams.
`timescale 1ns / 100ps

module testbench;
  import fcfs_pkg::*;

  localparam int JOB_SLOTS    = 64;
  localparam int SERVER_SLOTS = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 75;
  localparam int PHASES       = 6;
  localparam int SETTLE_CYCLES = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [NS_W-1:0]        cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // in_tdata: job_id[6:0], weight[13:7], amount[20:14], zero [23:21].
  logic [IN_TDATA_W-1:0]  in_tdata;
  // in_tuser: op.
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // out_tdata: server[2:0], slot_busy[3], served_id[10:4],
  // time_left[24:11], dropped[25], all_done[26], zero [31:27].
  logic [OUT_TDATA_W-1:0] out_tdata;
  // out_tuser: kind.
  logic                   out_tuser;
  logic                   out_tlast;

  int in_idle_pct;
  int out_idle_pct;

  // Keeps a shadow job table and the queue of result items still owed.
  class sched_scoreboard;
    logic [ID_W-1:0]   job_ids[JOB_SLOTS];
    logic [TIME_W-1:0] time_owed[JOB_SLOTS];
    int unsigned       jobs_held;
    logic [NS_W-1:0]   servers_cfg;
    res_t              owed_results[$];
    int unsigned       mismatches;

    function void clear();
      jobs_held = 0;
      servers_cfg = NS_W'(1);
      owed_results.delete();
      mismatches = 0;
    endfunction

    function void set_servers(logic [NS_W-1:0] value);
      servers_cfg = value;
    endfunction

    // True when no stored job has service time left.
    function bit table_finished();
      for (int i = 0; i < jobs_held; i++) begin
        if (time_owed[i] != 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Applies one accepted item to the shadow table and queues its results.
    function void note_item(logic op, logic [ID_W-1:0] id, logic [OPND_W-1:0] weight,
                            logic [OPND_W-1:0] amount);
      res_t              step_res[$];
      res_t              r;
      logic [TIME_W-1:0] svc;
      int                lim;
      int                pos;
      int                s;
      bit                done;
      if (op == OP_ARRIVAL) begin
        r = '0;
        r.kind = KIND_ACK;
        r.served_id = id;
        if (jobs_held >= JOB_SLOTS) begin
          r.dropped = 1'b1;
        end else begin
          svc = weight * amount;
          job_ids[jobs_held] = id;
          time_owed[jobs_held] = svc;
          jobs_held++;
          r.time_left = svc;
        end
        step_res.push_back(r);
      end else begin
        // Server count: zero acts as one, large values saturate.
        lim = servers_cfg;
        if (lim == 0) lim = 1;
        if (lim > SERVER_SLOTS) lim = SERVER_SLOTS;
        if (lim > RESULT_CAP) lim = RESULT_CAP;
        pos = 0;
        for (s = 0; s < lim; s++) begin
          while (pos < jobs_held && time_owed[pos] == 0) pos++;
          r = '0;
          r.kind = KIND_SLOT;
          r.server = SRV_W'(s);
          if (pos < jobs_held) begin
            r.slot_busy = 1'b1;
            r.served_id = job_ids[pos];
            r.time_left = time_owed[pos];
            time_owed[pos] = time_owed[pos] - 1'b1;
            pos++;
          end
          step_res.push_back(r);
        end
      end
      done = table_finished();
      foreach (step_res[k]) begin
        step_res[k].all_done = done;
        step_res[k].last = (k == step_res.size() - 1);
        owed_results.push_back(step_res[k]);
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result item with the oldest owed one.
    function void check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $error("result item arrived with none owed");
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("server", want.server, got.server);
      compare_field("slot_busy", want.slot_busy, got.slot_busy);
      compare_field("served_id", want.served_id, got.served_id);
      compare_field("time_left", want.time_left, got.time_left);
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("all_done", want.all_done, got.all_done);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  sched_scoreboard sb;

  fcfs_multi_server_job_scheduler #(
    .MAX_JOBS   (JOB_SLOTS),
    .MAX_SERVERS(SERVER_SLOTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure, changed at the falling edge.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Result monitor, sampled at the rising edge.
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind      = out_tuser;
      got.server    = out_tdata[OB_SRV_LSB +: SRV_W];
      got.slot_busy = out_tdata[OB_BUSY];
      got.served_id = out_tdata[OB_ID_LSB +: ID_W];
      got.time_left = out_tdata[OB_LEFT_LSB +: TIME_W];
      got.dropped   = out_tdata[OB_DROP];
      got.all_done  = out_tdata[OB_DONE];
      got.last      = out_tlast;
      sb.check_result(got);
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one item, with random idle cycles first, and waits for acceptance.
  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [OPND_W-1:0] weight, input logic [OPND_W-1:0] amount);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {3'b000, amount, weight, id};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, id, weight, amount);
    @(negedge clk);
  endtask

  // Stops the input and waits until every owed result item has come back.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes num_servers; the block must be idle.
  task automatic write_servers(input logic [NS_W-1:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    sb.set_servers(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly ticks; arrivals are shaped so most jobs are short enough to finish.
  task automatic send_random_item();
    logic [ID_W-1:0]   id;
    logic [OPND_W-1:0] weight;
    logic [OPND_W-1:0] amount;
    id = ID_W'($urandom_range(0, 127));
    weight = OPND_W'($urandom_range(0, 127));
    amount = OPND_W'($urandom_range(0, 127));
    if ($urandom_range(0, 10) >= 2) begin
      send_item(OP_TICK, id, weight, amount);
    end else begin
      if (sb.jobs_held == JOB_SLOTS - 4) begin
        // The longest possible job, placed late so earlier jobs can finish.
        weight = '1;
        amount = '1;
      end else begin
        case ($urandom_range(0, 9))
          0: amount = '0;
          1: weight = '0;
          2: amount = OPND_W'(1);
          3: weight = OPND_W'(1);
          default: begin
            weight = OPND_W'($urandom_range(0, 4));
            amount = OPND_W'($urandom_range(0, 6));
          end
        endcase
      end
      send_item(OP_ARRIVAL, id, weight, amount);
    end
  endtask

  initial begin : stimulus
    int phase_servers[PHASES];
    int phase_in_idle[PHASES];
    int phase_out_idle[PHASES];
    phase_servers  = '{8, 0, 15, 1, 3, 8};
    phase_in_idle  = '{19, 19, 79, 79, 0, 0};
    phase_out_idle = '{79, 79, 19, 19, 0, 0};
    sb = new();
    sb.clear();
    in_idle_pct = 19;
    out_idle_pct = 79;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: one idle slot with the reset server count, then eight.
    send_item(OP_TICK, '1, '1, '1);
    drain_results();
    write_servers(4'd8);
    send_item(OP_TICK, '0, '0, '0);

    // Zero-time jobs, short jobs, then ticks until everything is done.
    send_item(OP_ARRIVAL, 7'd0, 7'd0, 7'd99);
    send_item(OP_ARRIVAL, 7'd127, 7'd127, 7'd0);
    send_item(OP_ARRIVAL, 7'd99, 7'd2, 7'd3);
    send_item(OP_ARRIVAL, 7'd85, 7'd1, 7'd1);
    send_item(OP_ARRIVAL, 7'd42, 7'd3, 7'd1);
    send_item(OP_ARRIVAL, 7'd7, 7'd0, 7'd0);
    repeat (7) begin
      send_item(OP_TICK, ID_W'($urandom_range(0, 127)),
                OPND_W'($urandom_range(0, 127)), 7'd0);
    end

    // Two servers on a job already finished and a new one.
    drain_results();
    write_servers(4'd2);
    send_item(OP_ARRIVAL, 7'd13, 7'd2, 7'd2);
    repeat (5) send_item(OP_TICK, 7'd0, 7'd0, 7'd0);

    // Random phases over server counts and idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 4) phase_servers[p] = $urandom_range(2, 7);
      write_servers(NS_W'(phase_servers[p]));
      in_idle_pct = phase_in_idle[p];
      out_idle_pct = phase_out_idle[p];
      repeat (RANDOM_ITEMS) send_random_item();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.owed_results.size() != 0) begin
      $error("%0d result items never arrived", sb.owed_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fcfs_pkg.sv
rtl/fcfs_front.sv
rtl/fcfs_queue.sv
rtl/fcfs_back.sv
rtl/fcfs_multi_server_job_scheduler.sv
rtl/fcfs_checker.sv
tb/sv/testbench.sv
